### design/t0pbr_pkg.sv
// shared types and constants for the t=0 case-2 procedure byte receiver
package t0pbr_pkg;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 48;

  localparam logic [7:0] ProcNull  = 8'h60;
  localparam logic [3:0] SwGroupA  = 4'h6;
  localparam logic [3:0] SwGroupB  = 4'h9;
  localparam logic [7:0] InvMask   = 8'hFF;
  localparam logic [8:0] MaxData   = 9'd256;
  localparam logic [2:0] HdrLast   = 3'd4;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_BYTE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_HDR  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_DONE = 2'd2
  } kind_e;

  typedef enum logic [6:0] {
    PH_IDLE      = 7'b0000001,
    PH_PROC      = 7'b0000010,
    PH_BLOCK     = 7'b0000100,
    PH_SINGLE    = 7'b0001000,
    PH_SW2_AFTER = 7'b0010000,
    PH_SW1_FINAL = 7'b0100000,
    PH_SW2_FINAL = 7'b1000000
  } phase_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] class_byte;
    logic [7:0] instruction;
    logic [7:0] param_one;
    logic [7:0] param_two;
    logic [7:0] expected_length;
    logic [7:0] card_byte;
  } item_t;

  // one result descriptor; a header run expands to five words downstream
  typedef struct packed {
    logic       is_hdr;
    logic [7:0] class_byte;
    logic [7:0] instruction;
    logic [7:0] param_one;
    logic [7:0] param_two;
    logic [7:0] expected_length;
    kind_e      kind;
    logic [7:0] byte_value;
    logic [7:0] byte_index;
    logic [7:0] status_one;
    logic [7:0] status_two;
    logic [8:0] data_count;
  } res_t;

endpackage

### design/t0pbr_ctrl.sv
// procedure byte state machine and transaction counters
module t0pbr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  t0pbr_pkg::item_t item_i,
  input  logic             res_free_i,
  output logic             take_o,
  output logic             res_load_o,
  output t0pbr_pkg::res_t  res_o
);

  t0pbr_pkg::phase_e phase_q, phase_d;
  logic [7:0] ins_q, ins_d;
  logic [8:0] tgt_q, tgt_d;
  logic [8:0] rcv_q, rcv_d;
  logic [7:0] sw1_q, sw1_d;
  logic       produces;
  logic [8:0] rcv_inc;
  logic [7:0] b;

  assign b       = item_i.card_byte;
  assign rcv_inc = rcv_q + 9'd1;

  always_comb begin
    phase_d  = phase_q;
    ins_d    = ins_q;
    tgt_d    = tgt_q;
    rcv_d    = rcv_q;
    sw1_d    = sw1_q;
    produces = 1'b0;
    res_o    = '0;
    res_o.kind = t0pbr_pkg::KIND_HDR;
    if (item_i.command == t0pbr_pkg::CMD_START) begin
      produces              = 1'b1;
      res_o.is_hdr          = 1'b1;
      res_o.class_byte      = item_i.class_byte;
      res_o.instruction     = item_i.instruction;
      res_o.param_one       = item_i.param_one;
      res_o.param_two       = item_i.param_two;
      res_o.expected_length = item_i.expected_length;
      ins_d   = item_i.instruction;
      tgt_d   = (item_i.expected_length != 8'd0) ? {1'b0, item_i.expected_length}
                                                 : t0pbr_pkg::MaxData;
      rcv_d   = '0;
      sw1_d   = '0;
      phase_d = t0pbr_pkg::PH_PROC;
    end else begin
      unique case (phase_q)
        t0pbr_pkg::PH_PROC: begin
          priority if (b == t0pbr_pkg::ProcNull) begin
            phase_d = t0pbr_pkg::PH_PROC;
          end else if (b == ins_q) begin
            phase_d = t0pbr_pkg::PH_BLOCK;
          end else if ((b ^ t0pbr_pkg::InvMask) == ins_q) begin
            phase_d = t0pbr_pkg::PH_SINGLE;
          end else if (b[7:4] == t0pbr_pkg::SwGroupA || b[7:4] == t0pbr_pkg::SwGroupB) begin
            sw1_d   = b;
            phase_d = t0pbr_pkg::PH_SW2_AFTER;
          end else begin
            phase_d = t0pbr_pkg::PH_PROC;
          end
        end
        t0pbr_pkg::PH_BLOCK, t0pbr_pkg::PH_SINGLE: begin
          produces         = 1'b1;
          res_o.kind       = t0pbr_pkg::KIND_DATA;
          res_o.byte_value = b;
          res_o.byte_index = rcv_q[7:0];
          rcv_d            = rcv_inc;
          if (rcv_inc >= tgt_q) begin
            phase_d = t0pbr_pkg::PH_SW1_FINAL;
          end else if (phase_q == t0pbr_pkg::PH_SINGLE) begin
            phase_d = t0pbr_pkg::PH_PROC;
          end
        end
        t0pbr_pkg::PH_SW2_AFTER, t0pbr_pkg::PH_SW2_FINAL: begin
          produces         = 1'b1;
          res_o.kind       = t0pbr_pkg::KIND_DONE;
          res_o.status_one = sw1_q;
          res_o.status_two = b;
          res_o.data_count = rcv_q;
          phase_d          = t0pbr_pkg::PH_IDLE;
        end
        t0pbr_pkg::PH_SW1_FINAL: begin
          sw1_d   = b;
          phase_d = t0pbr_pkg::PH_SW2_FINAL;
        end
        default: begin
          phase_d = t0pbr_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // card bytes that cause no word never wait on the output side
  assign take_o     = in_valid_i && (!produces || res_free_i);
  assign res_load_o = take_o && produces;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= t0pbr_pkg::PH_IDLE;
      ins_q   <= '0;
      tgt_q   <= '0;
      rcv_q   <= '0;
      sw1_q   <= '0;
    end else if (take_o) begin
      phase_q <= phase_d;
      ins_q   <= ins_d;
      tgt_q   <= tgt_d;
      rcv_q   <= rcv_d;
      sw1_q   <= sw1_d;
    end
  end

`ifndef SYNTH
  a_rcv_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rcv_q <= tgt_q)
    else $error("received count passed target");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load_o |-> res_free_i)
    else $error("result loaded into busy output stage");
  a_data_phase_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == t0pbr_pkg::PH_BLOCK || phase_q == t0pbr_pkg::PH_SINGLE) |-> rcv_q < tgt_q)
    else $error("data phase with no bytes left");
`endif

endmodule

### design/t0pbr_out.sv
// output word register; expands a header descriptor into five words
module t0pbr_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  t0pbr_pkg::res_t res_i,
  output logic            free_o,
  output logic            valid_o,
  input  logic            ready_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      byte_value_o,
  output logic [7:0]      byte_index_o,
  output logic [7:0]      status_one_o,
  output logic [7:0]      status_two_o,
  output logic [8:0]      data_count_o,
  output logic            last_o
);

  logic            valid_q;
  t0pbr_pkg::res_t res_q;
  logic [2:0]      beat_q;
  logic            final_beat;
  logic            word_done;
  logic [7:0]      hdr_byte;

  assign final_beat = !res_q.is_hdr || (beat_q == t0pbr_pkg::HdrLast);
  assign word_done  = valid_q && ready_i;
  assign free_o     = !valid_q || (ready_i && final_beat);
  assign valid_o    = valid_q;

  always_comb begin
    unique case (beat_q)
      3'd0:    hdr_byte = res_q.class_byte;
      3'd1:    hdr_byte = res_q.instruction;
      3'd2:    hdr_byte = res_q.param_one;
      3'd3:    hdr_byte = res_q.param_two;
      default: hdr_byte = res_q.expected_length;
    endcase
  end

  always_comb begin
    if (res_q.is_hdr) begin
      kind_o       = t0pbr_pkg::KIND_HDR;
      byte_value_o = hdr_byte;
      byte_index_o = {5'd0, beat_q};
      status_one_o = '0;
      status_two_o = '0;
      data_count_o = '0;
      last_o       = (beat_q == t0pbr_pkg::HdrLast);
    end else begin
      kind_o       = res_q.kind;
      byte_value_o = res_q.byte_value;
      byte_index_o = res_q.byte_index;
      status_one_o = res_q.status_one;
      status_two_o = res_q.status_two;
      data_count_o = res_q.data_count;
      last_o       = (res_q.kind == t0pbr_pkg::KIND_DONE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      beat_q  <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      beat_q  <= '0;
    end else if (word_done) begin
      valid_q <= !final_beat;
      beat_q  <= final_beat ? 3'd0 : beat_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

`ifndef SYNTH
  a_beat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> beat_q <= t0pbr_pkg::HdrLast)
    else $error("header beat out of range");
  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !res_q.is_hdr) |-> beat_q == 3'd0)
    else $error("beat count moved on a single word");
  a_load_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("load over a pending word");
`endif

endmodule

### design/t0_case2_procedure_byte_receiver.sv
// t=0 case-2 reader: input register, procedure state machine, output word register
// an item is registered on accept; a word it yields is then loaded into the output register
// a card byte per cycle while the output is free; a start item holds it for five header words
// card bytes that cause no word (null, ack, sw1) drain at one per cycle without waiting on output
// reset (async, active low): phase idle, counters and held sw1 cleared, no word pending
module t0_case2_procedure_byte_receiver (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // class_byte, instruction, param_one, param_two, expected_length, card_byte
  input  logic [t0pbr_pkg::InDataW-1:0]     s_axis_tdata_i,
  // command
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // byte_value, byte_index, status_one, status_two, data_count, zero pad
  output logic [t0pbr_pkg::OutDataW-1:0]    m_axis_tdata_o,
  // kind
  output logic [1:0]                        m_axis_tuser_o,
  output logic                              m_axis_tlast_o
);

  logic             in_valid_q;
  t0pbr_pkg::item_t item_q;
  logic             take;
  logic             res_load;
  logic             res_free;
  t0pbr_pkg::res_t  res;
  logic             s_accept;
  logic [7:0]       byte_value;
  logic [7:0]       byte_index;
  logic [7:0]       status_one;
  logic [7:0]       status_two;
  logic [8:0]       data_count;

  assign s_axis_tready_o = !in_valid_q || take;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (take) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      item_q.command         <= t0pbr_pkg::cmd_e'(s_axis_tuser_i);
      item_q.class_byte      <= s_axis_tdata_i[7:0];
      item_q.instruction     <= s_axis_tdata_i[15:8];
      item_q.param_one       <= s_axis_tdata_i[23:16];
      item_q.param_two       <= s_axis_tdata_i[31:24];
      item_q.expected_length <= s_axis_tdata_i[39:32];
      item_q.card_byte       <= s_axis_tdata_i[47:40];
    end
  end

  t0pbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_q),
    .item_i     (item_q),
    .res_free_i (res_free),
    .take_o     (take),
    .res_load_o (res_load),
    .res_o      (res)
  );

  t0pbr_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (res_load),
    .res_i        (res),
    .free_o       (res_free),
    .valid_o      (m_axis_tvalid_o),
    .ready_i      (m_axis_tready_i),
    .kind_o       (m_axis_tuser_o),
    .byte_value_o (byte_value),
    .byte_index_o (byte_index),
    .status_one_o (status_one),
    .status_two_o (status_two),
    .data_count_o (data_count),
    .last_o       (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {7'd0, data_count, status_two, status_one, byte_index, byte_value};

endmodule

### tb/t0_case2_procedure_byte_receiver_test.sv
// testbench for the t=0 case-2 procedure byte receiver: directed table, random exchanges, checker
`timescale 1ns / 100ps

module t0_case2_procedure_byte_receiver_test;
  import t0pbr_pkg::*;

  localparam int unsigned HalfPeriod  = 10;
  localparam int unsigned ResetCycles = 12;
  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned RandomItems = 120;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned MaxGap      = 14;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
    logic [7:0] index;
    logic [7:0] sw1;
    logic [7:0] sw2;
    logic [8:0] count;
    logic       last;
  } word_t;

  // how a stimulus row is checked: by the predictor, not at all, or against values typed in the row
  typedef enum logic [1:0] {
    CHK_MODEL = 2'd0,
    CHK_NONE  = 2'd1,
    CHK_DATA  = 2'd2,
    CHK_DONE  = 2'd3
  } row_chk_e;

  // t_a/t_b: data value and index, or sw1 and sw2; t_cnt: data count on completion
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] cla;
    logic [7:0] ins;
    logic [7:0] p1;
    logic [7:0] p2;
    logic [7:0] le;
    logic [7:0] card;
    row_chk_e   chk;
    logic [7:0] t_a;
    logic [7:0] t_b;
    logic [8:0] t_cnt;
  } row_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  // class_byte, instruction, param_one, param_two, expected_length, card_byte
  logic [InDataW-1:0]   s_axis_tdata_i  = '0;
  // command
  logic                 s_axis_tuser_i  = 1'b0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  // byte_value, byte_index, status_one, status_two, data_count, zero pad
  logic [OutDataW-1:0]  m_axis_tdata_o;
  // kind
  logic [1:0]           m_axis_tuser_o;
  logic                 m_axis_tlast_o;

  // reader state as predicted
  phase_e      rd_phase  = PH_IDLE;
  logic [7:0]  rd_ins    = '0;
  logic [8:0]  rd_target = '0;
  logic [8:0]  rd_count  = '0;
  logic [7:0]  rd_sw1    = '0;

  word_t       awaited_words [$];
  row_t        dir_rows [0:24];
  int unsigned errors        = 0;
  int unsigned items_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned cycle_count   = 0;
  bit          tx_quiet      = 1'b0;
  bit          rx_quiet      = 1'b0;
  bit          hold_req      = 1'b0;

  t0_case2_procedure_byte_receiver uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic word_t mk_word(input kind_e kind, input logic [7:0] value,
                                    input logic [7:0] index, input logic [7:0] sw1,
                                    input logic [7:0] sw2, input logic [8:0] count,
                                    input logic last);
    word_t w;
    w.kind  = kind;
    w.value = value;
    w.index = index;
    w.sw1   = sw1;
    w.sw2   = sw2;
    w.count = count;
    w.last  = last;
    return w;
  endfunction

  function automatic string word_str(input word_t w);
    return $sformatf("kind=%0d value=%02h index=%0d sw1=%02h sw2=%02h count=%0d last=%0b",
                     w.kind, w.value, w.index, w.sw1, w.sw2, w.count, w.last);
  endfunction

  function automatic row_t rnd_row(input cmd_e cmd);
    row_t r;
    r      = '0;
    r.cmd  = cmd;
    r.cla  = 8'($urandom);
    r.ins  = 8'($urandom);
    r.p1   = 8'($urandom);
    r.p2   = 8'($urandom);
    r.le   = 8'($urandom);
    r.card = 8'($urandom);
    r.chk  = CHK_MODEL;
    return r;
  endfunction

  // advance the predicted reader by one input item; queue the words it yields when asked to
  task automatic reader_step(input row_t r, input bit keep);
    word_t w [$];
    if (r.cmd == CMD_START) begin
      rd_ins    = r.ins;
      rd_target = (r.le != 8'd0) ? {1'b0, r.le} : MaxData;
      rd_count  = '0;
      rd_sw1    = '0;
      w.push_back(mk_word(KIND_HDR, r.cla, 8'd0, '0, '0, '0, 1'b0));
      w.push_back(mk_word(KIND_HDR, r.ins, 8'd1, '0, '0, '0, 1'b0));
      w.push_back(mk_word(KIND_HDR, r.p1, 8'd2, '0, '0, '0, 1'b0));
      w.push_back(mk_word(KIND_HDR, r.p2, 8'd3, '0, '0, '0, 1'b0));
      w.push_back(mk_word(KIND_HDR, r.le, {5'd0, HdrLast}, '0, '0, '0, 1'b1));
      rd_phase = PH_PROC;
    end else begin
      case (rd_phase)
        PH_PROC: begin
          // null wins over an ack, so an instruction of 0x60 can never ack a block
          if (r.card == ProcNull) begin
          end else if (r.card == rd_ins) begin
            rd_phase = PH_BLOCK;
          end else if ((r.card ^ InvMask) == rd_ins) begin
            rd_phase = PH_SINGLE;
          end else if (r.card[7:4] == SwGroupA || r.card[7:4] == SwGroupB) begin
            rd_sw1   = r.card;
            rd_phase = PH_SW2_AFTER;
          end
        end
        PH_BLOCK, PH_SINGLE: begin
          w.push_back(mk_word(KIND_DATA, r.card, rd_count[7:0], '0, '0, '0, 1'b0));
          rd_count = rd_count + 9'd1;
          if (rd_count >= rd_target) begin
            rd_phase = PH_SW1_FINAL;
          end else if (rd_phase == PH_SINGLE) begin
            rd_phase = PH_PROC;
          end
        end
        PH_SW2_AFTER, PH_SW2_FINAL: begin
          w.push_back(mk_word(KIND_DONE, '0, '0, rd_sw1, r.card, rd_count, 1'b1));
          rd_phase = PH_IDLE;
        end
        PH_SW1_FINAL: begin
          rd_sw1   = r.card;
          rd_phase = PH_SW2_FINAL;
        end
        default: rd_phase = PH_IDLE;
      endcase
    end
    if (keep) begin
      foreach (w[i]) awaited_words.push_back(w[i]);
    end
  endtask

  task automatic send_item(input row_t r);
    int unsigned gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= r.cmd;
    s_axis_tdata_i  <= {r.card, r.le, r.p2, r.p1, r.ins, r.cla};
    do @(posedge clk_i); while (!s_axis_tready_o);
    // card words while idle are dropped by the block and not counted
    if (r.cmd == CMD_START || rd_phase != PH_IDLE) items_sent++;
    reader_step(r, r.chk == CHK_MODEL);
    case (r.chk)
      CHK_DATA: awaited_words.push_back(mk_word(KIND_DATA, r.t_a, r.t_b, '0, '0, '0, 1'b0));
      CHK_DONE: awaited_words.push_back(mk_word(KIND_DONE, '0, '0, r.t_a, r.t_b, r.t_cnt,
                                                1'b1));
      default: ;
    endcase
    gap = tx_quiet ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // one exchange steered by the predicted phase: mostly well formed, with nulls,
  // stray bytes, early status and the odd restart mixed in
  task automatic random_exchange();
    row_t        r;
    int unsigned pick;
    r    = rnd_row(CMD_START);
    r.le = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(1, 6)) : 8'($urandom);
    send_item(r);
    while (rd_phase != PH_IDLE) begin
      r    = rnd_row(CMD_BYTE);
      pick = $urandom_range(0, 99);
      if (rd_phase == PH_PROC) begin
        if (pick < 3) begin
          r = rnd_row(CMD_START);
          r.le = 8'($urandom_range(1, 6));
        end else if (pick < 10) begin
          r.card = ProcNull;
        end else if (pick < 18) begin
        end else if (pick < 26 || (rd_target - rd_count > 9'd8 && pick < 60)) begin
          r.card = {pick[0] ? SwGroupA : SwGroupB, 4'($urandom)};
        end else if (pick < 70 && rd_ins != ProcNull && rd_target - rd_count <= 9'd8) begin
          r.card = rd_ins;
        end else begin
          r.card = rd_ins ^ InvMask;
        end
      end
      send_item(r);
    end
  endtask

  // block transfer sent back to back; the receiver holds off meanwhile so the block backs up
  task automatic long_transfer();
    row_t r;
    tx_quiet = 1'b1;
    rx_quiet = 1'b0;
    r    = rnd_row(CMD_START);
    r.le = 8'd24;
    if (r.ins == ProcNull) r.ins = ~r.ins;
    send_item(r);
    r      = rnd_row(CMD_BYTE);
    r.card = rd_ins;
    hold_req = 1'b1;
    send_item(r);
    while (rd_phase != PH_IDLE) send_item(rnd_row(CMD_BYTE));
  endtask

  // output side: random stalls per word, one long hold-off on request
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap      = HoldCycles;
      end else begin
        gap = rx_quiet ? 0 : $urandom_range(0, MaxGap);
      end
      if (gap != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  always @(posedge clk_i) begin : word_check
    word_t got;
    word_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = mk_word(kind_e'(m_axis_tuser_o), m_axis_tdata_o[7:0], m_axis_tdata_o[15:8],
                    m_axis_tdata_o[23:16], m_axis_tdata_o[31:24], m_axis_tdata_o[40:32],
                    m_axis_tlast_o);
      if (awaited_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual %s", $time, word_str(got));
      end else begin
        want = awaited_words.pop_front();
        words_checked++;
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch, expected %s", $time, word_str(want));
          $display("%0t:           actual   %s", $time, word_str(got));
        end
      end
    end
  end

  initial begin
    int unsigned base;
    dir_rows = '{
      // card byte while idle
      '{CMD_BYTE,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, CHK_NONE, 8'h00, 8'h00, 9'd0},
      // zero header with le of one, one byte via single ack after a null
      '{CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, CHK_MODEL, 8'h00, 8'h00, 9'd0},
      '{CMD_BYTE,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h60, CHK_NONE, 8'h00, 8'h00, 9'd0},
      '{CMD_BYTE,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, CHK_NONE, 8'h00, 8'h00, 9'd0},
      '{CMD_BYTE,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hA5, CHK_DATA, 8'hA5, 8'h00, 9'd0},
      '{CMD_BYTE,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h90, CHK_NONE, 8'h00, 8'h00, 9'd0},
      '{CMD_BYTE,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, CHK_DONE, 8'h90, 8'h00, 9'd1},
      // all-ones header with le of 256, early status
      '{CMD_START, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, CHK_MODEL, 8'h00, 8'h00, 9'd0},
      '{CMD_BYTE,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h6C, CHK_NONE, 8'h00, 8'h00, 9'd0},
      '{CMD_BYTE,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, CHK_DONE, 8'h6C, 8'hFF, 9'd0},
      // instruction equal to null: 0x60 stays null, its complement acks one byte
      '{CMD_START, 8'hA0, 8'h60, 8'h5A, 8'hC3, 8'h02, 8'h00, CHK_MODEL, 8'h00, 8'h00, 9'd0},
      '{CMD_BYTE,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h60, CHK_NONE, 8'h00, 8'h00, 9'd0},
      '{CMD_BYTE,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h9F, CHK_NONE, 8'h00, 8'h00, 9'd0},
      '{CMD_BYTE,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h11, CHK_DATA, 8'h11, 8'h00, 9'd0},
      '{CMD_BYTE,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h12, CHK_NONE, 8'h00, 8'h00, 9'd0},
      '{CMD_BYTE,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h60, CHK_NONE, 8'h00, 8'h00, 9'd0},
      '{CMD_BYTE,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h61, CHK_NONE, 8'h00, 8'h00, 9'd0},
      '{CMD_BYTE,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h10, CHK_DONE, 8'h61, 8'h10, 9'd1},
      // block ack, then a restart in the middle of the data
      '{CMD_START, 8'h80, 8'hB0, 8'h01, 8'h02, 8'h03, 8'h00, CHK_MODEL, 8'h00, 8'h00, 9'd0},
      '{CMD_BYTE,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hB0, CHK_NONE, 8'h00, 8'h00, 9'd0},
      '{CMD_BYTE,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, CHK_MODEL, 8'h00, 8'h00, 9'd0},
      '{CMD_BYTE,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, CHK_MODEL, 8'h00, 8'h00, 9'd0},
      '{CMD_START, 8'h00, 8'hC0, 8'h00, 8'h00, 8'h04, 8'h00, CHK_MODEL, 8'h00, 8'h00, 9'd0},
      '{CMD_BYTE,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h6A, CHK_NONE, 8'h00, 8'h00, 9'd0},
      '{CMD_BYTE,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h82, CHK_DONE, 8'h6A, 8'h82, 9'd0}
    };
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_item(dir_rows[i]);

    base = items_sent;
    while (items_sent - base < RandomItems) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 2)) send_item(rnd_row(CMD_BYTE));
      end
      random_exchange();
    end

    long_transfer();
    s_axis_tvalid_i <= 1'b0;

    while (awaited_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run: %0d words sent, %0d output words checked", items_sent, words_checked);
    $display("run: table cases, random exchanges with restarts, a block ack under a long stall");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
